// ----- rtl/fbsp_pkg.sv -----
// fbsp_pkg: shared types and constants of the frame buffer slot pool
`timescale 1ns / 1ps
`default_nettype none
package fbsp_pkg;

    localparam int CFG_W       = 13;   // widest register
    localparam int CFG_IDX_W   = 3;
    localparam int DIM_W       = 13;
    localparam int FMT_W       = 2;
    localparam int SLOTCFG_W   = 5;
    localparam int OP_W        = 2;
    localparam int REL_W       = 4;
    localparam int ADDR_W      = 30;
    localparam int STRIDE_W    = 13;
    localparam int FSIZE_OUT_W = 27;
    localparam int ACT_W       = 5;
    localparam int STAT_W      = 32;
    localparam int PROD_W      = 2 * DIM_W;     // width times height
    localparam int FSIZE_W     = PROD_W + 2;    // up to four bytes per pixel
    localparam int VOFF_W      = PROD_W + 1;

    localparam logic [STAT_W-1:0] STAT_MAX = '1;
    localparam logic [ACT_W-1:0]  ACT_MAX  = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_PIXEL_FORMAT = 3'd2,
        REG_SLOT_COUNT   = 3'd3
    } t_cfg_reg;

    typedef enum logic [FMT_W-1:0] {
        FMT_YUV420P = 2'd0,
        FMT_NV12    = 2'd1,
        FMT_RGB24   = 2'd2,
        FMT_RGBA8   = 2'd3
    } t_fmt;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [REL_W-1:0] slot_to_release;
    } t_req;

    typedef struct packed {
        logic [FSIZE_W-1:0]   fsize;    // zero when the geometry is invalid
        logic [PROD_W-1:0]    pix;      // luma plane bytes
        logic [VOFF_W-1:0]    v_off;    // luma plus one quarter plane
        logic [DIM_W-1:0]     width;
        t_fmt                 fmt;
        logic [SLOTCFG_W-1:0] nslots;   // usable slots, zero when disabled
    } t_geom;

    typedef struct packed {
        logic                   granted;
        logic [REL_W-1:0]       slot_id;
        logic [ADDR_W-1:0]      luma_address;
        logic [ADDR_W-1:0]      chroma_address;
        logic [ADDR_W-1:0]      v_address;
        logic [STRIDE_W-1:0]    luma_stride;
        logic [STRIDE_W-1:0]    chroma_stride;
        logic [FSIZE_OUT_W-1:0] frame_size;
        logic [ACT_W-1:0]       active_count;
        logic [ACT_W-1:0]       peak_count;
        logic [STAT_W-1:0]      acquisition_count;
        logic [STAT_W-1:0]      reuse_count;
    } t_rsp;

endpackage
`default_nettype wire

// ----- rtl/fbsp_req_if.sv -----
// fbsp_req_if: request channel carrying one pool operation per word
`timescale 1ns / 1ps
`default_nettype none
interface fbsp_req_if;
    logic                        valid;
    logic                        ready;
    logic [fbsp_pkg::OP_W-1:0]   op;
    logic [fbsp_pkg::REL_W-1:0]  slot_to_release;

    modport source (output valid, output op, output slot_to_release, input ready);
    modport sink   (input valid, input op, input slot_to_release, output ready);
endinterface
`default_nettype wire

// ----- rtl/fbsp_rsp_if.sv -----
// fbsp_rsp_if: result channel carrying one pool result per word
`timescale 1ns / 1ps
`default_nettype none
interface fbsp_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              granted;
    logic [fbsp_pkg::REL_W-1:0]        slot_id;
    logic [fbsp_pkg::ADDR_W-1:0]       luma_address;
    logic [fbsp_pkg::ADDR_W-1:0]       chroma_address;
    logic [fbsp_pkg::ADDR_W-1:0]       v_address;
    logic [fbsp_pkg::STRIDE_W-1:0]     luma_stride;
    logic [fbsp_pkg::STRIDE_W-1:0]     chroma_stride;
    logic [fbsp_pkg::FSIZE_OUT_W-1:0]  frame_size;
    logic [fbsp_pkg::ACT_W-1:0]        active_count;
    logic [fbsp_pkg::ACT_W-1:0]        peak_count;
    logic [fbsp_pkg::STAT_W-1:0]       acquisition_count;
    logic [fbsp_pkg::STAT_W-1:0]       reuse_count;

    modport source (
        output valid, output granted, output slot_id, output luma_address,
        output chroma_address, output v_address, output luma_stride,
        output chroma_stride, output frame_size, output active_count,
        output peak_count, output acquisition_count, output reuse_count,
        input ready
    );
    modport sink (
        input valid, input granted, input slot_id, input luma_address,
        input chroma_address, input v_address, input luma_stride,
        input chroma_stride, input frame_size, input active_count,
        input peak_count, input acquisition_count, input reuse_count,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/fbsp_geometry.sv -----
// fbsp_geometry: configuration registers and two-stage frame geometry pipeline
`timescale 1ns / 1ps
`default_nettype none
module fbsp_geometry #(
    parameter int MAX_SLOTS     = 16,
    parameter int MAX_DIMENSION = 4096,
    parameter int MAX_PIXELS    = 16777216
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fbsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fbsp_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                                o_pool_clear,
    output fbsp_pkg::t_geom                     o_geom
);

    logic [fbsp_pkg::DIM_W-1:0]     r_width,  n_width;
    logic [fbsp_pkg::DIM_W-1:0]     r_height, n_height;
    fbsp_pkg::t_fmt                 r_fmt,    n_fmt;
    logic [fbsp_pkg::SLOTCFG_W-1:0] r_slots,  n_slots;

    logic [fbsp_pkg::PROD_W-1:0]    r_pix,     n_pix;
    logic                           r_dims_ok, n_dims_ok;
    fbsp_pkg::t_geom                r_geom,    n_geom;

    logic [fbsp_pkg::FSIZE_W-1:0]   fsize_raw;
    logic                           size_ok;
    logic                           fmt_planar;

    // register writes; a write to a listed register rebuilds the pool
    always_comb begin
        n_width      = r_width;
        n_height     = r_height;
        n_fmt        = r_fmt;
        n_slots      = r_slots;
        o_pool_clear = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                fbsp_pkg::REG_FRAME_WIDTH: begin
                    n_width      = i_cfg_data[fbsp_pkg::DIM_W-1:0];
                    o_pool_clear = 1'b1;
                end
                fbsp_pkg::REG_FRAME_HEIGHT: begin
                    n_height     = i_cfg_data[fbsp_pkg::DIM_W-1:0];
                    o_pool_clear = 1'b1;
                end
                fbsp_pkg::REG_PIXEL_FORMAT: begin
                    n_fmt        = fbsp_pkg::t_fmt'(i_cfg_data[fbsp_pkg::FMT_W-1:0]);
                    o_pool_clear = 1'b1;
                end
                fbsp_pkg::REG_SLOT_COUNT: begin
                    n_slots      = i_cfg_data[fbsp_pkg::SLOTCFG_W-1:0];
                    o_pool_clear = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // first stage: pixel count and dimension checks
    always_comb begin
        fmt_planar = (r_fmt == fbsp_pkg::FMT_YUV420P) || (r_fmt == fbsp_pkg::FMT_NV12);
        n_pix      = fbsp_pkg::PROD_W'(r_width) * fbsp_pkg::PROD_W'(r_height);
        n_dims_ok  = (r_width != '0) && (r_height != '0)
                   && (32'(r_width) <= 32'(MAX_DIMENSION))
                   && (32'(r_height) <= 32'(MAX_DIMENSION))
                   && (!fmt_planar || (!r_width[0] && !r_height[0]));
    end

    // second stage: frame size, plane offsets and usable slot count
    always_comb begin
        size_ok = r_dims_ok && (32'(r_pix) <= 32'(MAX_PIXELS));
        case (r_fmt)
            fbsp_pkg::FMT_RGB24:
                fsize_raw = fbsp_pkg::FSIZE_W'(r_pix) + fbsp_pkg::FSIZE_W'({r_pix, 1'b0});
            fbsp_pkg::FMT_RGBA8:
                fsize_raw = fbsp_pkg::FSIZE_W'({r_pix, 2'b00});
            default:
                fsize_raw = fbsp_pkg::FSIZE_W'(r_pix) + fbsp_pkg::FSIZE_W'(r_pix >> 1);
        endcase
        n_geom.fsize  = size_ok ? fsize_raw : '0;
        n_geom.pix    = r_pix;
        n_geom.v_off  = fbsp_pkg::VOFF_W'(r_pix) + fbsp_pkg::VOFF_W'(r_pix >> 2);
        n_geom.width  = r_width;
        n_geom.fmt    = r_fmt;
        if (!size_ok) begin
            n_geom.nslots = '0;
        end else if (32'(r_slots) > 32'(MAX_SLOTS)) begin
            n_geom.nslots = fbsp_pkg::SLOTCFG_W'(MAX_SLOTS);
        end else begin
            n_geom.nslots = r_slots;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= '0;
            r_height  <= '0;
            r_fmt     <= fbsp_pkg::FMT_YUV420P;
            r_slots   <= '0;
            r_pix     <= '0;
            r_dims_ok <= 1'b0;
            r_geom    <= '0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_fmt     <= n_fmt;
            r_slots   <= n_slots;
            r_pix     <= n_pix;
            r_dims_ok <= n_dims_ok;
            r_geom    <= n_geom;
        end
    end

    assign o_geom = r_geom;

endmodule
`default_nettype wire

// ----- rtl/fbsp_alloc.sv -----
// fbsp_alloc: busy bitmap, lowest-free-slot search, counters and result fields
`timescale 1ns / 1ps
`default_nettype none
module fbsp_alloc #(
    parameter int MAX_SLOTS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic            i_clear,
    input  wire fbsp_pkg::t_req  i_req,
    input  wire fbsp_pkg::t_geom i_geom,
    output fbsp_pkg::t_rsp       o_rsp
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PRODA_W = SLOT_W + fbsp_pkg::FSIZE_W;

    logic [MAX_SLOTS-1:0]          r_busy,   n_busy;
    logic [fbsp_pkg::STAT_W-1:0]   r_acq,    n_acq;
    logic [fbsp_pkg::STAT_W-1:0]   r_reuse,  n_reuse;
    logic [fbsp_pkg::ACT_W-1:0]    r_active, n_active;
    logic [fbsp_pkg::ACT_W-1:0]    r_peak,   n_peak;

    logic [MAX_SLOTS-1:0]          free_slot;
    logic                          found;
    logic [SLOT_W-1:0]             idx;
    logic [SLOT_W-1:0]             rel_idx;
    logic                          rel_ok;
    logic [PRODA_W-1:0]            base;
    logic [fbsp_pkg::ADDR_W-1:0]   luma;

    always_comb begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            free_slot[i] = !r_busy[i] && (32'(i) < 32'(i_geom.nslots));
        end
        // lowest free slot wins
        found = 1'b0;
        idx   = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (free_slot[i]) begin
                found = 1'b1;
                idx   = SLOT_W'(i);
            end
        end

        rel_idx = SLOT_W'(i_req.slot_to_release);
        rel_ok  = (32'(i_req.slot_to_release) < 32'(i_geom.nslots)) && r_busy[rel_idx];

        base = PRODA_W'(idx) * PRODA_W'(i_geom.fsize);
        luma = base[fbsp_pkg::ADDR_W-1:0];

        n_busy   = r_busy;
        n_acq    = r_acq;
        n_reuse  = r_reuse;
        n_active = r_active;
        n_peak   = r_peak;
        o_rsp    = '0;

        case (i_req.op)
            fbsp_pkg::OP_ACQUIRE: begin
                if (found) begin
                    n_busy[idx] = 1'b1;
                    if (r_acq != fbsp_pkg::STAT_MAX) begin
                        n_acq = r_acq + 1'b1;
                    end
                    if (r_active != fbsp_pkg::ACT_MAX) begin
                        n_active = r_active + 1'b1;
                    end
                    if (n_active > r_peak) begin
                        n_peak = n_active;
                    end
                    if ((n_acq > fbsp_pkg::STAT_W'(i_geom.nslots))
                            && (r_reuse != fbsp_pkg::STAT_MAX)) begin
                        n_reuse = r_reuse + 1'b1;
                    end
                    o_rsp.granted      = 1'b1;
                    o_rsp.slot_id      = fbsp_pkg::REL_W'(idx);
                    o_rsp.luma_address = luma;
                    if (i_geom.fmt == fbsp_pkg::FMT_YUV420P) begin
                        o_rsp.chroma_address = luma + fbsp_pkg::ADDR_W'(i_geom.pix);
                        o_rsp.v_address      = luma + fbsp_pkg::ADDR_W'(i_geom.v_off);
                        o_rsp.luma_stride    = i_geom.width;
                        o_rsp.chroma_stride  = i_geom.width >> 1;
                    end else if (i_geom.fmt == fbsp_pkg::FMT_NV12) begin
                        o_rsp.chroma_address = luma + fbsp_pkg::ADDR_W'(i_geom.pix);
                        o_rsp.luma_stride    = i_geom.width;
                        o_rsp.chroma_stride  = i_geom.width;
                    end
                end
            end
            fbsp_pkg::OP_RELEASE: begin
                if (rel_ok) begin
                    n_busy[rel_idx] = 1'b0;
                    if (r_active != '0) begin
                        n_active = r_active - 1'b1;
                    end
                end
            end
            default: begin
                // query, and the unused code that behaves as one
            end
        endcase

        o_rsp.frame_size        = i_geom.fsize[fbsp_pkg::FSIZE_OUT_W-1:0];
        o_rsp.active_count      = n_active;
        o_rsp.peak_count        = n_peak;
        o_rsp.acquisition_count = n_acq;
        o_rsp.reuse_count       = n_reuse;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_busy   <= '0;
            r_acq    <= '0;
            r_reuse  <= '0;
            r_active <= '0;
            r_peak   <= '0;
        end else if (i_fire) begin
            r_busy   <= n_busy;
            r_acq    <= n_acq;
            r_reuse  <= n_reuse;
            r_active <= n_active;
            r_peak   <= n_peak;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/frame_buffer_slot_pool_unit.sv -----
// frame_buffer_slot_pool_unit: top level of the frame buffer slot pool
//
//   channel   dir   handshake       payload
//   i_req     in    valid / ready   op, slot_to_release
//   o_rsp     out   valid / ready   granted, slot_id, addresses, strides, counters
//   i_cfg     in    i_cfg_we only   i_cfg_index, i_cfg_data
//
// one word per cycle while o_rsp is ready and no register write settles; a request taken
// fills the input register, then the result register behind slot search and address multiply
// a register write rebuilds the pool at once and holds ready low for the following cycle
// while the geometry pipeline settles
// reset clears the registers, the bitmap and all counters; a stalled result holds its
// register and the request register fills behind it before ready drops
`timescale 1ns / 1ps
`default_nettype none
module frame_buffer_slot_pool_unit #(
    parameter int MAX_SLOTS     = 16,
    parameter int MAX_DIMENSION = 4096,
    parameter int MAX_PIXELS    = 16777216
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fbsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fbsp_pkg::CFG_W-1:0]     i_cfg_data,
    fbsp_req_if.sink                            i_req,
    fbsp_rsp_if.source                          o_rsp
);

    logic             r_in_valid;
    fbsp_pkg::t_req   r_req;
    logic             r_out_valid;
    fbsp_pkg::t_rsp   r_rsp;
    logic             r_settle;

    logic             pool_clear;
    fbsp_pkg::t_geom  geom;
    fbsp_pkg::t_rsp   step_rsp;
    logic             advance;
    logic             in_ready;
    logic             in_take;

    fbsp_geometry #(
        .MAX_SLOTS     (MAX_SLOTS),
        .MAX_DIMENSION (MAX_DIMENSION),
        .MAX_PIXELS    (MAX_PIXELS)
    ) u_geometry (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pool_clear (pool_clear),
        .o_geom       (geom)
    );

    fbsp_alloc #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_alloc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_clear (pool_clear),
        .i_req   (r_req),
        .i_geom  (geom),
        .o_rsp   (step_rsp)
    );

    // the request word moves on when the result register is empty or being taken
    assign advance  = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready = !r_settle && (!r_in_valid || advance);
    assign in_take  = i_req.valid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_settle    <= 1'b0;
        end else begin
            r_in_valid  <= in_take || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && !o_rsp.ready);
            r_settle    <= pool_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req.op              <= i_req.op;
            r_req.slot_to_release <= i_req.slot_to_release;
        end
        if (advance) begin
            r_rsp <= step_rsp;
        end
    end

    assign i_req.ready             = in_ready;
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.granted           = r_rsp.granted;
    assign o_rsp.slot_id           = r_rsp.slot_id;
    assign o_rsp.luma_address      = r_rsp.luma_address;
    assign o_rsp.chroma_address    = r_rsp.chroma_address;
    assign o_rsp.v_address         = r_rsp.v_address;
    assign o_rsp.luma_stride       = r_rsp.luma_stride;
    assign o_rsp.chroma_stride     = r_rsp.chroma_stride;
    assign o_rsp.frame_size        = r_rsp.frame_size;
    assign o_rsp.active_count      = r_rsp.active_count;
    assign o_rsp.peak_count        = r_rsp.peak_count;
    assign o_rsp.acquisition_count = r_rsp.acquisition_count;
    assign o_rsp.reuse_count       = r_rsp.reuse_count;

endmodule
`default_nettype wire

// ----- bench/frame_buffer_slot_pool_unit_test.sv -----
// testbench for the frame buffer slot pool: random pool traffic checked against a slot model
`timescale 1ns / 1ps
module frame_buffer_slot_pool_unit_test;
    import fbsp_pkg::*;

    localparam int POOL_SLOTS  = 16;
    localparam int DIM_LIMIT   = 4096;
    localparam longint unsigned PIXEL_LIMIT = 64'd16777216;
    localparam int ACTIVE_CAP  = 31;
    localparam longint unsigned COUNT_CAP = 64'hFFFF_FFFF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDX_TOP     = (1 << CFG_IDX_W) - 1;
    localparam int PHASES      = 26;
    localparam int PHASE_WORDS = 40;

    // slot bitmap, counters and geometry as the block should hold them
    class slot_pool_model;
        logic [DIM_W-1:0]     width_reg;
        logic [DIM_W-1:0]     height_reg;
        logic [FMT_W-1:0]     format_reg;
        logic [SLOTCFG_W-1:0] slots_reg;
        bit                   busy [POOL_SLOTS];
        longint unsigned      acquired;
        longint unsigned      reused;
        int                   active;
        int                   peak;
        t_rsp                 pending_results [$];
        int                   mismatches;

        function new();
            width_reg  = '0;
            height_reg = '0;
            format_reg = '0;
            slots_reg  = '0;
            mismatches = 0;
            clear_pool();
        endfunction

        function void clear_pool();
            foreach (busy[i]) busy[i] = 1'b0;
            acquired = 0;
            reused   = 0;
            active   = 0;
            peak     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            case (index)
                REG_FRAME_WIDTH:  width_reg  = data[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_reg = data[DIM_W-1:0];
                REG_PIXEL_FORMAT: format_reg = data[FMT_W-1:0];
                REG_SLOT_COUNT:   slots_reg  = data[SLOTCFG_W-1:0];
                default:          return;
            endcase
            clear_pool();
        endfunction

        function longint unsigned bytes_per_frame();
            longint unsigned w;
            longint unsigned h;
            longint unsigned pix;
            w = width_reg;
            h = height_reg;
            if (w == 0 || h == 0 || w > DIM_LIMIT || h > DIM_LIMIT) return 0;
            pix = w * h;
            if (pix > PIXEL_LIMIT) return 0;
            if (format_reg == FMT_YUV420P || format_reg == FMT_NV12) begin
                if (w[0] || h[0]) return 0;
                return pix + pix / 2;
            end
            if (format_reg == FMT_RGB24) return pix * 3;
            return pix * 4;
        endfunction

        // a borrowed slot at random, or the fallback when none is borrowed
        function logic [REL_W-1:0] borrowed_slot(logic [REL_W-1:0] fallback);
            int taken [$];
            foreach (busy[i]) if (busy[i]) taken.push_back(i);
            if (taken.size() == 0) return fallback;
            return REL_W'(taken[$urandom_range(0, taken.size() - 1)]);
        endfunction

        function void take_request(logic [OP_W-1:0] op, logic [REL_W-1:0] rel);
            t_rsp            want;
            longint unsigned fsize;
            longint unsigned pix;
            longint unsigned base;
            longint unsigned chroma;
            longint unsigned vaddr;
            int              nslots;
            int              idx;
            want  = '0;
            fsize = bytes_per_frame();
            nslots = 0;
            if (fsize != 0) nslots = (slots_reg > POOL_SLOTS) ? POOL_SLOTS : int'(slots_reg);
            if (op == OP_ACQUIRE) begin
                idx = 0;
                while (idx < nslots && busy[idx]) idx++;
                if (idx < nslots) begin
                    pix = longint'(width_reg) * longint'(height_reg);
                    busy[idx] = 1'b1;
                    if (acquired < COUNT_CAP) acquired++;
                    if (active < ACTIVE_CAP) active++;
                    if (active > peak) peak = active;
                    if (acquired > nslots && reused < COUNT_CAP) reused++;
                    base   = longint'(idx) * fsize;
                    chroma = base + pix;
                    vaddr  = chroma + pix / 4;
                    want.granted      = 1'b1;
                    want.slot_id      = idx[REL_W-1:0];
                    want.luma_address = base[ADDR_W-1:0];
                    if (format_reg == FMT_YUV420P) begin
                        want.chroma_address = chroma[ADDR_W-1:0];
                        want.v_address      = vaddr[ADDR_W-1:0];
                        want.luma_stride    = width_reg;
                        want.chroma_stride  = width_reg >> 1;
                    end else if (format_reg == FMT_NV12) begin
                        want.chroma_address = chroma[ADDR_W-1:0];
                        want.luma_stride    = width_reg;
                        want.chroma_stride  = width_reg;
                    end
                end
            end else if (op == OP_RELEASE) begin
                if (rel < nslots && busy[rel]) begin
                    busy[rel] = 1'b0;
                    if (active > 0) active--;
                end
            end
            want.frame_size        = fsize[FSIZE_OUT_W-1:0];
            want.active_count      = active[ACT_W-1:0];
            want.peak_count        = peak[ACT_W-1:0];
            want.acquisition_count = acquired[STAT_W-1:0];
            want.reuse_count       = reused[STAT_W-1:0];
            pending_results.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(t_rsp seen);
            t_rsp want;
            if (pending_results.size() == 0) begin
                $display("%0t result word with none expected: expected nothing actual slot %0d",
                         $time, seen.slot_id);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("granted", 32'(want.granted), 32'(seen.granted));
            compare_field("slot_id", 32'(want.slot_id), 32'(seen.slot_id));
            compare_field("luma_address", 32'(want.luma_address), 32'(seen.luma_address));
            compare_field("chroma_address", 32'(want.chroma_address),
                          32'(seen.chroma_address));
            compare_field("v_address", 32'(want.v_address), 32'(seen.v_address));
            compare_field("luma_stride", 32'(want.luma_stride), 32'(seen.luma_stride));
            compare_field("chroma_stride", 32'(want.chroma_stride), 32'(seen.chroma_stride));
            compare_field("frame_size", 32'(want.frame_size), 32'(seen.frame_size));
            compare_field("active_count", 32'(want.active_count), 32'(seen.active_count));
            compare_field("peak_count", 32'(want.peak_count), 32'(seen.peak_count));
            compare_field("acquisition_count", want.acquisition_count, seen.acquisition_count);
            compare_field("reuse_count", want.reuse_count, seen.reuse_count);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    t_rsp                 seen_word;
    slot_pool_model       pool;

    fbsp_req_if req_ch ();
    fbsp_rsp_if rsp_ch ();

    frame_buffer_slot_pool_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // holds the word until it is taken; valid stays high for a following word
    task automatic send_op(logic [OP_W-1:0] op, logic [REL_W-1:0] rel);
        req_ch.valid           <= 1'b1;
        req_ch.op              <= op;
        req_ch.slot_to_release <= rel;
        do @(posedge i_clk); while (!req_ch.ready);
        pool.take_request(op, rel);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge i_clk);
        pool.write_reg(index, data);
    endtask

    task automatic configure_pool(int w, int h, logic [FMT_W-1:0] fmt, int slots);
        write_reg(REG_FRAME_WIDTH, w[CFG_W-1:0]);
        write_reg(REG_FRAME_HEIGHT, h[CFG_W-1:0]);
        write_reg(REG_PIXEL_FORMAT, CFG_W'(fmt));
        write_reg(REG_SLOT_COUNT, slots[CFG_W-1:0]);
        cfg_we <= 1'b0;
    endtask

    function automatic int random_dimension();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, (1 << DIM_W) - 1);
            1:       return DIM_LIMIT;
            2:       return 2 * $urandom_range(0, 31) + 1;
            default: return 2 * $urandom_range(1, 32);
        endcase
    endfunction

    task automatic random_setup();
        int slots;
        case ($urandom_range(0, 5))
            // an unused index must leave the pool as it stands
            0: begin
                write_reg(CFG_IDX_W'($urandom_range(REG_SLOT_COUNT + 1, IDX_TOP)),
                          CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));
                cfg_we <= 1'b0;
            end
            1: begin
                write_reg(CFG_IDX_W'($urandom_range(REG_FRAME_WIDTH, REG_SLOT_COUNT)),
                          CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));
                cfg_we <= 1'b0;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       slots = $urandom_range(0, (1 << SLOTCFG_W) - 1);
                    1:       slots = POOL_SLOTS;
                    default: slots = $urandom_range(1, 8);
                endcase
                configure_pool(random_dimension(), random_dimension(),
                               FMT_W'($urandom_range(FMT_YUV420P, FMT_RGBA8)), slots);
            end
        endcase
    endtask

    task automatic random_items(int count, int acquire_pct, bit with_gaps);
        int               burst_left;
        int               pick;
        logic [OP_W-1:0]  op;
        logic [REL_W-1:0] rel;
        burst_left = 0;
        repeat (count) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                if (with_gaps) pause_sender($urandom_range(0, 6));
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            rel  = REL_W'($urandom_range(0, POOL_SLOTS - 1));
            if (pick < acquire_pct) begin
                op = OP_ACQUIRE;
            end else if (pick < acquire_pct + 30) begin
                op = OP_RELEASE;
                if ($urandom_range(0, 4) != 0) rel = pool.borrowed_slot(rel);
            end else if (pick < 95) begin
                op = OP_QUERY;
            end else begin
                op = OP_UNUSED;
            end
            send_op(op, rel);
        end
    endtask

    // wait for every expected word, then let the pipeline empty
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pool.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : result_sink
        logic [15:0] stall_pattern;
        int          pattern_age;
        rsp_ch.ready  = 1'b0;
        stall_pattern = '1;
        pattern_age   = 0;
        forever begin
            @(posedge i_clk);
            if (pattern_age == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = 16'($urandom);
                    2:       stall_pattern = 16'($urandom | $urandom);
                    default: stall_pattern = 16'($urandom & $urandom);
                endcase
                pattern_age = $urandom_range(16, 96);
            end
            pattern_age--;
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            rsp_ch.ready <= stall_pattern[0];
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            seen_word.granted           = rsp_ch.granted;
            seen_word.slot_id           = rsp_ch.slot_id;
            seen_word.luma_address      = rsp_ch.luma_address;
            seen_word.chroma_address    = rsp_ch.chroma_address;
            seen_word.v_address         = rsp_ch.v_address;
            seen_word.luma_stride       = rsp_ch.luma_stride;
            seen_word.chroma_stride     = rsp_ch.chroma_stride;
            seen_word.frame_size        = rsp_ch.frame_size;
            seen_word.active_count      = rsp_ch.active_count;
            seen_word.peak_count        = rsp_ch.peak_count;
            seen_word.acquisition_count = rsp_ch.acquisition_count;
            seen_word.reuse_count       = rsp_ch.reuse_count;
            pool.check_result(seen_word);
        end
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int phase;
        pool                   = new();
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        req_ch.valid           = 1'b0;
        req_ch.op              = OP_QUERY;
        req_ch.slot_to_release = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty geometry straight out of reset
        send_op(OP_QUERY, 4'd0);
        send_op(OP_ACQUIRE, 4'd0);
        send_op(OP_RELEASE, 4'd0);
        settle();

        configure_pool(64, 32, FMT_YUV420P, 4);
        repeat (5) send_op(OP_ACQUIRE, 4'd0);   // last one finds the pool full
        send_op(OP_RELEASE, 4'd2);
        send_op(OP_RELEASE, 4'd2);              // no longer borrowed
        send_op(OP_RELEASE, 4'd9);              // outside the pool
        send_op(OP_QUERY, 4'd15);
        send_op(OP_UNUSED, 4'd15);
        send_op(OP_ACQUIRE, 4'd0);              // takes the lowest free slot back
        send_op(OP_RELEASE, 4'd0);
        send_op(OP_ACQUIRE, 4'd0);              // acquisitions keep exceeding the slot count
        send_op(OP_RELEASE, 4'd15);
        send_op(OP_ACQUIRE, 4'd0);
        send_op(OP_RELEASE, 4'd3);
        send_op(OP_RELEASE, 4'd1);
        settle();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       configure_pool(DIM_LIMIT, DIM_LIMIT, FMT_RGBA8, POOL_SLOTS);
                1:       configure_pool(DIM_LIMIT, DIM_LIMIT, FMT_YUV420P, 31);
                2:       configure_pool(DIM_LIMIT, DIM_LIMIT, FMT_NV12, POOL_SLOTS);
                3:       configure_pool(8191, 8191, FMT_RGB24, POOL_SLOTS);
                4:       configure_pool(DIM_LIMIT + 1, 2, FMT_RGB24, 4);
                5:       configure_pool(33, 17, FMT_YUV420P, 8);   // odd planar geometry
                6:       configure_pool(1, 1, FMT_RGB24, 1);
                7:       configure_pool(0, 64, FMT_RGBA8, 4);
                8:       configure_pool(66, 34, FMT_NV12, 0);      // pool switched off
                9:       configure_pool(2, 2, FMT_YUV420P, 17);
                default: random_setup();
            endcase
            random_items(PHASE_WORDS, (phase < 3) ? 65 : $urandom_range(35, 65),
                         $urandom_range(0, 3) != 0);
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (pool.mismatches == 0 && pool.pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- frame_buffer_slot_pool_unit.f -----
rtl/fbsp_pkg.sv
rtl/fbsp_req_if.sv
rtl/fbsp_rsp_if.sv
rtl/fbsp_geometry.sv
rtl/fbsp_alloc.sv
rtl/frame_buffer_slot_pool_unit.sv
bench/frame_buffer_slot_pool_unit_test.sv
